[rtl/crcht_pkg.sv]
// Shared types, codes and the CRC-32C word step for the chained hash table.
// No dependencies; imported by the top level and its checker.
package crcht_pkg;

    localparam int DEF_SLOTS           = 1024;
    localparam int DEF_MAX_BUCKET_BITS = 12;
    localparam int DEF_VALUE_BITS      = 32;

    localparam logic [3:0]  BUCKET_BITS_RESET = 4'd12;
    localparam logic [31:0] CRC_POLY          = 32'h82F63B78;

    typedef enum logic [2:0] {
        ST_NOT_FOUND = 3'd0,
        ST_FOUND     = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_UPDATED   = 3'd3,
        ST_DELETED   = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    localparam logic [1:0] ACT_FIND   = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_BAD    = 2'd3;

    localparam logic [1:0] KSZ_4  = 2'd0;
    localparam logic [1:0] KSZ_8  = 2'd1;
    localparam logic [1:0] KSZ_16 = 2'd2;
    localparam logic [1:0] KSZ_BAD = 2'd3;

    // reflected CRC-32C over one 32-bit word, LSB first
    function automatic logic [31:0] crc_word(input logic [31:0] crc_in, input logic [31:0] word);
        logic [31:0] c;
        c = crc_in ^ word;
        for (int b = 0; b < 32; b++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

[rtl/crc32c_chained_hash_table.sv]
// Chained hash table keyed by CRC-32C: find, add-or-update, delete.
// Each request hashes W = 1, 2 or 4 key words, one per cycle, then reads the bucket
// head and walks the chain, one slot-memory read per entry visited; a bad key size
// skips straight to the result. A new transfer is taken only in the idle state.
// Reset: asynchronous, active low; a clearing pass over all 2**MAX_BUCKET_BITS bucket
// heads (4096 by default) empties the bucket-head memory before the first transfer.
module crc32c_chained_hash_table
    import crcht_pkg::*;
#(
    parameter int SLOTS           = crcht_pkg::DEF_SLOTS,
    parameter int MAX_BUCKET_BITS = crcht_pkg::DEF_MAX_BUCKET_BITS,
    parameter int VALUE_BITS      = crcht_pkg::DEF_VALUE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [1:0]  key_size,
    input  logic [63:0] key_low,
    input  logic [63:0] key_high,
    input  logic [31:0] new_value,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] result_value,
    output logic [11:0] bucket_index
);

    localparam int PTR_W   = $clog2(SLOTS + 1);   // slot pointer incl. nil
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int BKT_W   = MAX_BUCKET_BITS;
    localparam int BUCKETS = 1 << MAX_BUCKET_BITS;
    localparam int SLOT_W  = 2 + 64 + 64 + VALUE_BITS;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOTS);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_CMP, S_DECIDE,
        S_ALLOC, S_WR1, S_WR2, S_FINISH
    } state_t;

    state_t state_reg;

    logic [3:0]            bucket_bits_reg;
    logic [BKT_W-1:0]      clr_cnt_reg;
    logic [1:0]            action_reg;
    logic [1:0]            size_reg;
    logic [63:0]           klo_reg;
    logic [63:0]           khi_reg;
    logic [VALUE_BITS-1:0] nval_reg;
    logic [31:0]           crc_reg;
    logic [1:0]            word_reg;
    logic [BKT_W-1:0]      bucket_reg;
    logic [PTR_W-1:0]      cur_reg;
    logic [PTR_W-1:0]      prev_reg;
    logic [PTR_W-1:0]      hit_reg;
    logic [PTR_W-1:0]      hit_link_reg;
    logic [VALUE_BITS-1:0] hit_val_reg;
    logic [PTR_W-1:0]      splice_reg;    // new slot on add, successor on delete
    logic [PTR_W-1:0]      free_head_reg;
    logic [PTR_W-1:0]      fresh_reg;
    status_t               res_status_reg;
    logic [VALUE_BITS-1:0] res_value_reg;
    logic                  out_valid_reg;
    logic [2:0]            status_reg;
    logic [31:0]           value_reg;
    logic [11:0]           bucket_out_reg;

    // memory ports
    logic                  head_we;
    logic [BKT_W-1:0]      head_waddr;
    logic [PTR_W-1:0]      head_wdata;
    logic [BKT_W-1:0]      head_raddr;
    logic [PTR_W-1:0]      head_rdata;
    logic                  slot_we;
    logic [IDX_W-1:0]      slot_waddr;
    logic [SLOT_W-1:0]     slot_wdata;
    logic [IDX_W-1:0]      slot_raddr;
    logic [SLOT_W-1:0]     slot_rdata;
    logic                  link_we;
    logic [IDX_W-1:0]      link_waddr;
    logic [PTR_W-1:0]      link_wdata;
    logic [IDX_W-1:0]      link_raddr;
    logic [PTR_W-1:0]      link_rdata;

    // hash datapath
    logic [31:0]      hash_word;
    logic [31:0]      crc_next;
    logic             hash_last;
    logic [4:0]       bits_eff;
    logic [BKT_W-1:0] bkt_mask;
    logic [BKT_W-1:0] bucket_next;

    // chain compare
    logic [VALUE_BITS-1:0] rd_val;
    logic [63:0]           rd_klo;
    logic [63:0]           rd_khi;
    logic [1:0]            rd_size;
    logic                  key_match;
    logic [PTR_W-1:0]      walk_ptr;
    logic                  take_result;

    always_comb
    begin
        case (word_reg)
            2'd0:    hash_word = klo_reg[31:0];
            2'd1:    hash_word = klo_reg[63:32];
            2'd2:    hash_word = khi_reg[31:0];
            default: hash_word = khi_reg[63:32];
        endcase
        crc_next  = crc_word(crc_reg, hash_word);
        hash_last = (size_reg == KSZ_4 && word_reg == 2'd0) ||
                    (size_reg == KSZ_8 && word_reg == 2'd1) || (word_reg == 2'd3);
        if (bucket_bits_reg == 4'd0)
        begin
            bits_eff = 5'd1;
        end
        else if ({1'b0, bucket_bits_reg} > 5'(MAX_BUCKET_BITS))
        begin
            bits_eff = 5'(MAX_BUCKET_BITS);
        end
        else
        begin
            bits_eff = {1'b0, bucket_bits_reg};
        end
        bkt_mask    = BKT_W'((33'd1 << bits_eff) - 33'd1);
        bucket_next = BKT_W'(crc_next) & bkt_mask;
    end

    assign rd_val    = slot_rdata[VALUE_BITS-1:0];
    assign rd_klo    = slot_rdata[VALUE_BITS +: 64];
    assign rd_khi    = slot_rdata[VALUE_BITS+64 +: 64];
    assign rd_size   = slot_rdata[VALUE_BITS+128 +: 2];
    assign key_match = (rd_size == size_reg) && (rd_klo == klo_reg) && (rd_khi == khi_reg);
    assign walk_ptr  = (state_reg == S_HEAD) ? head_rdata : link_rdata;

    // memory port steering
    always_comb
    begin
        head_we    = 1'b0;
        head_waddr = bucket_reg;
        head_wdata = splice_reg;
        head_raddr = (state_reg == S_HASH) ? bucket_next : bucket_reg;
        slot_we    = 1'b0;
        slot_waddr = (state_reg == S_WR1) ? splice_reg[IDX_W-1:0] : hit_reg[IDX_W-1:0];
        slot_wdata = {size_reg, khi_reg, klo_reg, nval_reg};
        slot_raddr = walk_ptr[IDX_W-1:0];
        link_we    = 1'b0;
        link_waddr = splice_reg[IDX_W-1:0];
        link_wdata = NIL;
        link_raddr = (state_reg == S_DECIDE) ? free_head_reg[IDX_W-1:0]
                                             : walk_ptr[IDX_W-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_cnt_reg;
                head_wdata = NIL;
            end
            S_DECIDE:
            begin
                if (hit_reg != NIL && action_reg == ACT_ADD)
                begin
                    slot_we = 1'b1;
                end
                if (hit_reg != NIL && action_reg == ACT_DELETE)
                begin
                    // released slot heads the free list
                    link_we    = 1'b1;
                    link_waddr = hit_reg[IDX_W-1:0];
                    link_wdata = free_head_reg;
                end
            end
            S_WR1:
            begin
                slot_we = 1'b1;
                link_we = 1'b1;
            end
            S_WR2:
            begin
                if (prev_reg == NIL)
                begin
                    head_we = 1'b1;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg[IDX_W-1:0];
                    link_wdata = splice_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    crcht_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    crcht_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    crcht_ram #(.WIDTH(PTR_W), .DEPTH(SLOTS)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    assign take_result = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            bucket_bits_reg <= BUCKET_BITS_RESET;
            clr_cnt_reg     <= '0;
            action_reg      <= ACT_FIND;
            size_reg        <= KSZ_4;
            klo_reg         <= '0;
            khi_reg         <= '0;
            nval_reg        <= '0;
            crc_reg         <= '0;
            word_reg        <= '0;
            bucket_reg      <= '0;
            cur_reg         <= NIL;
            prev_reg        <= NIL;
            hit_reg         <= NIL;
            hit_link_reg    <= NIL;
            hit_val_reg     <= '0;
            splice_reg      <= NIL;
            free_head_reg   <= NIL;
            fresh_reg       <= '0;
            res_status_reg  <= ST_NOT_FOUND;
            res_value_reg   <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= '0;
            value_reg       <= '0;
            bucket_out_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                bucket_bits_reg <= cfg_wr_data;
            end
            // result register: load from S_FINISH, drop once transferred
            if (state_reg == S_FINISH && take_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == BKT_W'(BUCKETS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        // mask key bytes beyond the size
                        action_reg <= action;
                        size_reg   <= key_size;
                        klo_reg    <= (key_size == KSZ_4) ? {32'd0, key_low[31:0]} : key_low;
                        khi_reg    <= (key_size == KSZ_16) ? key_high : 64'd0;
                        nval_reg   <= VALUE_BITS'(new_value);
                        crc_reg    <= '0;
                        word_reg   <= '0;
                        hit_reg    <= NIL;
                        prev_reg   <= NIL;
                        if (key_size == KSZ_BAD)
                        begin
                            bucket_reg     <= '0;
                            res_status_reg <= ST_NOT_FOUND;
                            res_value_reg  <= '0;
                            state_reg      <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_HASH;
                        end
                    end
                end
                S_HASH:
                begin
                    crc_reg  <= crc_next;
                    word_reg <= word_reg + 1'b1;
                    if (hash_last)
                    begin
                        bucket_reg <= bucket_next;
                        state_reg  <= S_HEAD;
                    end
                end
                S_HEAD:
                begin
                    cur_reg <= head_rdata;
                    if (head_rdata == NIL)
                    begin
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    if (key_match)
                    begin
                        hit_reg      <= cur_reg;
                        hit_link_reg <= link_rdata;
                        hit_val_reg  <= rd_val;
                        state_reg    <= S_DECIDE;
                    end
                    else
                    begin
                        prev_reg <= cur_reg;
                        cur_reg  <= link_rdata;
                        if (link_rdata == NIL)
                        begin
                            state_reg <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE:
                begin
                    res_status_reg <= ST_NOT_FOUND;
                    res_value_reg  <= '0;
                    state_reg      <= S_FINISH;
                    case (action_reg)
                        ACT_FIND:
                        begin
                            if (hit_reg != NIL)
                            begin
                                res_status_reg <= ST_FOUND;
                                res_value_reg  <= hit_val_reg;
                            end
                        end
                        ACT_ADD:
                        begin
                            if (hit_reg != NIL)
                            begin
                                res_status_reg <= ST_UPDATED;
                                res_value_reg  <= hit_val_reg;
                            end
                            else if (free_head_reg != NIL)
                            begin
                                splice_reg <= free_head_reg;
                                state_reg  <= S_ALLOC;
                            end
                            else if (fresh_reg != NIL)
                            begin
                                splice_reg <= fresh_reg;
                                fresh_reg  <= fresh_reg + 1'b1;
                                state_reg  <= S_WR1;
                            end
                            else
                            begin
                                res_status_reg <= ST_FULL;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (hit_reg != NIL)
                            begin
                                free_head_reg <= hit_reg;
                                splice_reg    <= hit_link_reg;
                                state_reg     <= S_WR2;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_ALLOC:
                begin
                    free_head_reg <= link_rdata;
                    state_reg     <= S_WR1;
                end
                S_WR1:
                begin
                    state_reg <= S_WR2;
                end
                S_WR2:
                begin
                    if (action_reg == ACT_DELETE)
                    begin
                        res_status_reg <= ST_DELETED;
                        res_value_reg  <= hit_val_reg;
                    end
                    else
                    begin
                        res_status_reg <= ST_INSERTED;
                        res_value_reg  <= '0;
                    end
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (take_result)
                    begin
                        status_reg     <= res_status_reg;
                        value_reg      <= 32'(res_value_reg);
                        bucket_out_reg <= 12'(bucket_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_value = value_reg;
    assign bucket_index = bucket_out_reg;

endmodule

[rtl/crcht_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module crcht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/crcht_chk.sv]
// Port-level checker for the chained hash table, bound to the top level.
// Depends on crcht_pkg for the status codes.
module crcht_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [31:0] result_value
);
    import crcht_pkg::*;

    // one request in flight: an accepted transfer closes the input
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted twice in a row");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_value))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_FULL)
        else $error("status code out of range");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NOT_FOUND || status == ST_INSERTED || status == ST_FULL)
        |-> result_value == 32'd0)
        else $error("nonzero value with empty status");

endmodule

bind crc32c_chained_hash_table crcht_chk u_crcht_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .result_value (result_value)
);
